// ----- src/rte_pkg.sv -----
// Ranging timeout encoder package: control word types, step addresses,
// microprogram table and datapath constants. No dependencies.
package rte_pkg;

  // Datapath constants
  localparam int unsigned DIV_NUM_W   = 45;    // (timeout << 12) + macro/2
  localparam int unsigned PLL_ITERS   = 31;    // quotient bits of 2^30 / freq
  localparam int unsigned CNT_ITERS   = 45;    // quotient bits of count division
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned MANT_W      = 8;
  localparam int unsigned EXPO_W      = 5;     // exponent never exceeds 24
  localparam logic [11:0] MACRO_SCALE = 12'd2304;

  // Step addresses
  typedef logic [3:0] pc_t;
  localparam pc_t STEP_WAIT     = 4'd0;
  localparam pc_t STEP_PLL_INIT = 4'd1;
  localparam pc_t STEP_PLL_DIV  = 4'd2;
  localparam pc_t STEP_MUL1     = 4'd3;
  localparam pc_t STEP_MUL2     = 4'd4;
  localparam pc_t STEP_CNT_INIT = 4'd5;
  localparam pc_t STEP_CNT_DIV  = 4'd6;
  localparam pc_t STEP_ENC_INIT = 4'd7;
  localparam pc_t STEP_NORM     = 4'd8;
  localparam pc_t STEP_EMIT     = 4'd9;
  localparam pc_t STEP_RETURN   = 4'd10;
  localparam pc_t STEP_FAIL     = 4'd11;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_PLL_INIT,
    OP_DIV,
    OP_MUL1,
    OP_MUL2,
    OP_CNT_INIT,
    OP_ENC_INIT,
    OP_NORM,
    OP_EMIT,
    OP_FAIL
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_IN,
    C_FREQ_ZERO,
    C_LOOP_MORE,
    C_MACRO_ZERO,
    C_MANT_WIDE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctl_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic freq_zero;
    logic macro_zero;
    logic loop_more;
    logic mant_wide;
  } dp_flags_t;

  // Microprogram: jump to target when the condition holds, else fall through
  function automatic ctl_t rte_rom(input pc_t pc);
    ctl_t w;
    unique case (pc)
      STEP_WAIT:     w = '{OP_LOAD,     C_NO_IN,      STEP_WAIT};
      STEP_PLL_INIT: w = '{OP_PLL_INIT, C_FREQ_ZERO,  STEP_FAIL};
      STEP_PLL_DIV:  w = '{OP_DIV,      C_LOOP_MORE,  STEP_PLL_DIV};
      STEP_MUL1:     w = '{OP_MUL1,     C_NONE,       STEP_WAIT};
      STEP_MUL2:     w = '{OP_MUL2,     C_NONE,       STEP_WAIT};
      STEP_CNT_INIT: w = '{OP_CNT_INIT, C_MACRO_ZERO, STEP_FAIL};
      STEP_CNT_DIV:  w = '{OP_DIV,      C_LOOP_MORE,  STEP_CNT_DIV};
      STEP_ENC_INIT: w = '{OP_ENC_INIT, C_NONE,       STEP_WAIT};
      STEP_NORM:     w = '{OP_NORM,     C_MANT_WIDE,  STEP_NORM};
      STEP_EMIT:     w = '{OP_EMIT,     C_OUT_BUSY,   STEP_EMIT};
      STEP_RETURN:   w = '{OP_NOP,      C_ALWAYS,     STEP_WAIT};
      STEP_FAIL:     w = '{OP_FAIL,     C_ALWAYS,     STEP_EMIT};
      default:       w = '{OP_NOP,      C_ALWAYS,     STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- src/rte_sequencer.sv -----
// Microcode sequencer: step counter, program table lookup and jump logic.
// Depends on rte_pkg.
module rte_sequencer
  import rte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_busy,
  input  dp_flags_t flags,
  output ctl_t      ctl
);

  pc_t  pc_r;
  pc_t  pc_nxt;
  logic take;

  // Fetch the control word of the current step
  assign ctl = rte_rom(pc_r);

  // Evaluate the jump condition
  always_comb begin
    unique case (ctl.cond)
      C_NONE:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_IN:      take = !in_valid;
      C_FREQ_ZERO:  take = flags.freq_zero;
      C_LOOP_MORE:  take = flags.loop_more;
      C_MACRO_ZERO: take = flags.macro_zero;
      C_MANT_WIDE:  take = flags.mant_wide;
      C_OUT_BUSY:   take = out_busy;
      default:      take = 1'b0;
    endcase
  end

  // Jump or advance
  assign pc_nxt = take ? ctl.target : pc_t'(pc_r + pc_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- src/rte_datapath.sv -----
// Datapath: frequency register, shared restoring divider, two multiplies
// and the exponent normalizer, all driven by the control word. Depends on rte_pkg.
module rte_datapath
  import rte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  input  logic        in_accept,
  input  logic [5:0]  in_pulse_code,
  input  logic [31:0] in_phase_us,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output dp_flags_t   flags,
  output logic [31:0] res_macro_period,
  output logic [31:0] res_mclk_count,
  output logic [15:0] res_encoded_timeout,
  output logic        res_invalid
);

  logic [15:0]          freq_r;
  logic [5:0]           code_r;
  logic [31:0]          tus_r;
  logic                 inv_r,   inv_nxt;
  logic [DIV_NUM_W-1:0] num_r,   num_nxt;
  logic [31:0]          rem_r,   rem_nxt;
  logic [31:0]          quo_r,   quo_nxt;
  logic [31:0]          div_r,   div_nxt;
  logic [CNT_W-1:0]     cnt_r,   cnt_nxt;
  logic [31:0]          macro_r, macro_nxt;
  logic [31:0]          mant_r,  mant_nxt;
  logic [EXPO_W-1:0]    expo_r,  expo_nxt;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;
  logic [43:0] prod1;
  logic [7:0]  pclks;
  logic [33:0] prod2;

  // One restoring division step
  assign rem_sh  = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  // Multiplies, each on registered operands
  assign prod1 = quo_r * MACRO_SCALE;
  assign pclks = {(7'(code_r) + 7'd1), 1'b0};
  assign prod2 = macro_r[25:0] * pclks;

  always_comb begin
    inv_nxt   = inv_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    macro_nxt = macro_r;
    mant_nxt  = mant_r;
    expo_nxt  = expo_r;
    unique case (ctl.op)
      OP_LOAD: begin
        inv_nxt = 1'b0;
      end
      OP_PLL_INIT: begin
        // 2^30 left-aligned in the numerator shifter
        num_nxt = {1'b1, {(DIV_NUM_W-1){1'b0}}};
        rem_nxt = '0;
        quo_nxt = '0;
        div_nxt = {16'd0, freq_r};
        cnt_nxt = CNT_W'(PLL_ITERS);
      end
      OP_DIV: begin
        // High quotient bits fall off: count keeps its low 32 bits
        num_nxt = {num_r[DIV_NUM_W-2:0], 1'b0};
        rem_nxt = ge ? rem_sub[31:0] : rem_sh[31:0];
        quo_nxt = {quo_r[30:0], ge};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      OP_MUL1: begin
        macro_nxt = {6'd0, prod1[31:6]};
      end
      OP_MUL2: begin
        macro_nxt = {6'd0, prod2[31:6]};
      end
      OP_CNT_INIT: begin
        num_nxt = {1'b0, tus_r, 12'd0} + DIV_NUM_W'(macro_r >> 1);
        rem_nxt = '0;
        quo_nxt = '0;
        div_nxt = macro_r;
        cnt_nxt = CNT_W'(CNT_ITERS);
      end
      OP_ENC_INIT: begin
        // A zero count encodes to zero
        mant_nxt = (quo_r == '0) ? '0 : quo_r - 32'd1;
        expo_nxt = '0;
      end
      OP_NORM: begin
        if (flags.mant_wide) begin
          mant_nxt = mant_r >> 1;
          expo_nxt = expo_r + EXPO_W'(1);
        end
      end
      OP_FAIL: begin
        inv_nxt = 1'b1;
      end
      OP_NOP, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= '0;
    end else if (cfg_wr_en) begin
      freq_r <= cfg_wr_data;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      code_r <= in_pulse_code;
      tus_r  <= in_phase_us;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    inv_r   <= inv_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    div_r   <= div_nxt;
    cnt_r   <= cnt_nxt;
    macro_r <= macro_nxt;
    mant_r  <= mant_nxt;
    expo_r  <= expo_nxt;
  end

  // Status toward the sequencer
  assign flags.freq_zero  = (freq_r == '0);
  assign flags.macro_zero = (macro_r == '0);
  assign flags.loop_more  = (cnt_r != CNT_W'(1));
  assign flags.mant_wide  = |mant_r[31:MANT_W];

  // Result fields, zero when invalid
  assign res_invalid         = inv_r;
  assign res_macro_period    = inv_r ? '0 : macro_r;
  assign res_mclk_count      = inv_r ? '0 : quo_r;
  assign res_encoded_timeout = inv_r ? '0 :
                               {{(8-EXPO_W){1'b0}}, expo_r, mant_r[MANT_W-1:0]};

endmodule

// ----- src/ranging_timeout_encoder.sv -----
// Ranging timeout encoder top level: sequencer, datapath and output register.
// Depends on rte_pkg, rte_sequencer, rte_datapath.
//
//  channel | direction | tdata fields (low bit first)                       | tuser
//  in_     | slave     | pulse_code[5:0], phase_us[37:6], zero [39:38]      | -
//  out_    | master    | macro_period[31:0], mclk_count[63:32],             | invalid
//          |           | encoded_timeout[79:64]                              |
//  cfg_    | write     | fast_osc_frequency[15:0]                            | -
//
// An item passes from acceptance to result through two bit-serial
// divisions (31 and 45 steps) through one shared subtractor, plus up to
// 24 normalizing shifts of the exponent encoder; the next word waits for the emit step.
// An invalid item (zero frequency or zero macro period) skips the remaining divisions.
// Reset (rst_n low, synchronous) clears the step counter, the output valid and
// the frequency register. The next item is accepted while a result waits.
module ranging_timeout_encoder
  import rte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // pulse_code, phase_us
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,   // macro_period, mclk_count, encoded_timeout
  output logic        out_tuser,   // invalid
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  ctl_t      ctl;
  dp_flags_t flags;
  logic      out_busy;
  logic      emit;
  logic      out_valid_r;
  logic [79:0] out_data_r;
  logic        out_user_r;
  logic [31:0] res_macro_period;
  logic [31:0] res_mclk_count;
  logic [15:0] res_encoded_timeout;
  logic        res_invalid;

  assign in_tready = (ctl.op == OP_LOAD);
  assign out_busy  = out_valid_r && !out_tready;
  assign emit      = (ctl.op == OP_EMIT) && !out_busy;

  rte_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_busy (out_busy),
    .flags    (flags),
    .ctl      (ctl)
  );

  rte_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .in_accept           (in_tvalid && in_tready),
    .in_pulse_code       (in_tdata[5:0]),
    .in_phase_us         (in_tdata[37:6]),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .flags               (flags),
    .res_macro_period    (res_macro_period),
    .res_mclk_count      (res_mclk_count),
    .res_encoded_timeout (res_encoded_timeout),
    .res_invalid         (res_invalid)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {res_encoded_timeout, res_mclk_count, res_macro_period};
      out_user_r <= res_invalid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- src/rte_checker.sv -----
// Port-level checker for the ranging timeout encoder, bound to the top level.
// Depends on ranging_timeout_encoder ports only.
module rte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tuser
);

  // Stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // Invalid results carry zero fields
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 80'd0)
    else $error("invalid result with nonzero fields");

  // Valid results have a nonzero macro period
  a_macro_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:0] != 32'd0)
    else $error("valid result with zero macro period");

  // Zero count encodes to zero
  a_enc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[63:32] == 32'd0 |-> out_tdata[79:64] == 16'd0)
    else $error("zero count with nonzero encoding");

  // One item at a time: no acceptance right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted two items back to back");

endmodule

bind ranging_timeout_encoder rte_checker u_rte_checker (.*);
